FILE: rtl/core/gbfs_pkg.sv
// ---------------------------------------------------------------------------
// gbfs_pkg
// Shared sizes and opcodes for the breadth first search engine.
// ---------------------------------------------------------------------------
package gbfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;

  // Fixed port field widths
  localparam int VERT_W  = 6;
  localparam int COUNT_W = 7;

  // Derived storage sizes
  localparam int VIDX_W      = $clog2(MAX_VERTICES);
  localparam int CNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
  localparam int STORE_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_RUN    = 2'd2
  } opcode_t;

endpackage

FILE: rtl/core/gbfs_ram.sv
// ---------------------------------------------------------------------------
// gbfs_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gbfs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/graph_bfs_order_engine.sv
// ---------------------------------------------------------------------------
// graph_bfs_order_engine
// Adjacency list loader and breadth first walk with visit order output.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Clear never raises
// busy. Append raises busy (degree read, then store write). A run with a bad
// start gives its error result in the cycle after the command and never
// raises busy. A good run holds busy while it walks: each vertex costs a FIFO
// read, a degree read, then one neighbor store read per list entry through
// the single store read port. Results come as one-cycle pulses of
// result_valid and cannot be held off; the last result of a run is shown as
// busy falls.
// ---------------------------------------------------------------------------
module graph_bfs_order_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [gbfs_pkg::VERT_W-1:0] vertex,
  input  logic [gbfs_pkg::VERT_W-1:0] neighbor,
  input  logic                        cfg_write,
  input  logic [gbfs_pkg::COUNT_W-1:0] cfg_data,
  output logic                        result_valid,
  output logic [gbfs_pkg::VERT_W-1:0] visited_vertex,
  output logic [gbfs_pkg::VERT_W-1:0] order_position,
  output logic                        last_of_run,
  output logic                        start_error
);

  import gbfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_POP,
    S_DEG,
    S_SCAN
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   vertex_count;
  logic [COUNT_W-1:0]   live_n;
  logic [CNT_W-1:0]     head;
  logic [CNT_W-1:0]     tail;
  logic [CNT_W-1:0]     tail_after;
  logic [VERT_W-1:0]    cur;
  logic [VERT_W-1:0]    op_vertex;
  logic [VERT_W-1:0]    op_neighbor;
  logic [VERT_W-1:0]    pend_vertex;
  logic [VERT_W-1:0]    pend_pos;
  logic [DEG_W-1:0]     idx;
  logic                 nb_rvalid;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] deg_vld;

  logic                 accept;
  logic                 run_ok;
  logic                 result_valid_next;
  logic [VIDX_W-1:0]    deg_sel;
  logic [DEG_W-1:0]     deg_rdata;
  logic [DEG_W-1:0]     deg_eff;
  logic [VIDX_W-1:0]    deg_raddr;
  logic                 append_ok;
  logic                 scan_issue;
  logic                 push;
  logic [VERT_W-1:0]    nb_rdata;
  logic [VERT_W-1:0]    fifo_rdata;
  logic                 fifo_we;
  logic [VIDX_W-1:0]    fifo_waddr;
  logic [VERT_W-1:0]    fifo_wdata;
  logic [STORE_AW-1:0]  store_waddr;
  logic [STORE_AW-1:0]  store_raddr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign live_n = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                          : vertex_count;
  assign run_ok = (COUNT_W'(vertex) < live_n);

  // degree entries not written since the last clear read as zero
  assign deg_sel = (state == S_APPEND) ? op_vertex[VIDX_W-1:0] : cur[VIDX_W-1:0];
  assign deg_eff = deg_vld[deg_sel] ? deg_rdata : '0;

  assign append_ok = (state == S_APPEND) &&
                     (COUNT_W'(op_vertex) < live_n) &&
                     (COUNT_W'(op_neighbor) < live_n) &&
                     (deg_eff < DEG_W'(MAX_DEGREE));

  // degree read port follows the command in idle, the dequeued vertex after
  always_comb begin
    unique case (state)
      S_IDLE:  deg_raddr = vertex[VIDX_W-1:0];
      S_DEG:   deg_raddr = fifo_rdata[VIDX_W-1:0];
      default: deg_raddr = cur[VIDX_W-1:0];
    endcase
  end

  assign scan_issue = (state == S_SCAN) && (idx < deg_eff);
  assign push = (state == S_SCAN) && nb_rvalid &&
                (COUNT_W'(nb_rdata) < live_n) &&
                !visited[nb_rdata[VIDX_W-1:0]] &&
                (tail < CNT_W'(MAX_VERTICES));
  assign tail_after = push ? tail + CNT_W'(1) : tail;

  // bad start, a vertex closed by the next dequeue, or the end of the walk
  assign result_valid_next = (accept && (opcode == OP_RUN) && !run_ok) ||
                             ((state == S_DEG) && (head != '0)) ||
                             ((state == S_SCAN) && !scan_issue && !(head < tail_after));

  assign store_waddr = STORE_AW'(op_vertex) * STORE_AW'(MAX_DEGREE) + STORE_AW'(deg_eff);
  assign store_raddr = STORE_AW'(cur) * STORE_AW'(MAX_DEGREE) + STORE_AW'(idx);

  assign fifo_we    = push || (accept && (opcode == OP_RUN) && run_ok);
  assign fifo_waddr = push ? tail[VIDX_W-1:0] : '0;
  assign fifo_wdata = push ? nb_rdata : vertex;

  gbfs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degree (
    .clk   (clk),
    .we    (append_ok),
    .waddr (op_vertex[VIDX_W-1:0]),
    .wdata (deg_eff + DEG_W'(1)),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gbfs_ram #(.WIDTH(VERT_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (append_ok),
    .waddr (store_waddr),
    .wdata (op_neighbor),
    .raddr (store_raddr),
    .rdata (nb_rdata)
  );

  gbfs_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head[VIDX_W-1:0]),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= COUNT_W'(MAX_VERTICES);
      deg_vld      <= '0;
      visited      <= '0;
      head         <= '0;
      tail         <= '0;
      idx          <= '0;
      nb_rvalid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_CLEAR: begin
                deg_vld <= '0;
              end
              OP_APPEND: begin
                op_vertex   <= vertex;
                op_neighbor <= neighbor;
                state       <= S_APPEND;
              end
              OP_RUN: begin
                if (!run_ok) begin
                  visited_vertex <= '0;
                  order_position <= '0;
                  last_of_run    <= 1'b1;
                  start_error    <= 1'b1;
                end else begin
                  visited <= MAX_VERTICES'(1) << vertex[VIDX_W-1:0];
                  head    <= '0;
                  tail    <= CNT_W'(1);
                  state   <= S_POP;
                end
              end
              default: ;
            endcase
          end
        end
        S_APPEND: begin
          if (append_ok) begin
            deg_vld[op_vertex[VIDX_W-1:0]] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_POP: begin
          state <= S_DEG;
        end
        S_DEG: begin
          // previous vertex is known not to be last once another is dequeued
          if (head != '0) begin
            visited_vertex <= pend_vertex;
            order_position <= pend_pos;
            last_of_run    <= 1'b0;
            start_error    <= 1'b0;
          end
          pend_vertex <= fifo_rdata;
          pend_pos    <= VERT_W'(head);
          cur         <= fifo_rdata;
          head        <= head + CNT_W'(1);
          idx         <= '0;
          nb_rvalid   <= 1'b0;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          nb_rvalid <= scan_issue;
          if (scan_issue) begin
            idx <= idx + DEG_W'(1);
          end
          if (push) begin
            visited[nb_rdata[VIDX_W-1:0]] <= 1'b1;
            tail <= tail_after;
          end
          if (!scan_issue) begin
            if (head < tail_after) begin
              state <= S_POP;
            end else begin
              visited_vertex <= pend_vertex;
              order_position <= pend_pos;
              last_of_run    <= 1'b1;
              start_error    <= 1'b0;
              state          <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/gbfs_checker.sv
// ---------------------------------------------------------------------------
// gbfs_checker
// Port level checks of command timing and result framing.
// ---------------------------------------------------------------------------
module gbfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  opcode,
  input logic                        result_valid,
  input logic [gbfs_pkg::VERT_W-1:0] visited_vertex,
  input logic [gbfs_pkg::VERT_W-1:0] order_position,
  input logic                        last_of_run,
  input logic                        start_error
);

  import gbfs_pkg::*;

  // error result closes its run and carries zero fields
  a_err_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && start_error |->
      last_of_run && (visited_vertex == '0) && (order_position == '0))
    else $error("error result not framed as a single last result");

  // error result comes without entering the walk
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && start_error |-> !busy)
    else $error("busy during error result");

  // more results of the run follow while the walk is still going
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !start_error && !last_of_run |-> busy)
    else $error("non-last result shown after walk ended");

  // the last visit transaction ends the walk
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !start_error && last_of_run |-> !busy)
    else $error("walk still busy at last result");

  // append needs a degree read before its write
  a_append_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == OP_APPEND) |=> busy)
    else $error("append did not hold busy");

endmodule

bind graph_bfs_order_engine gbfs_checker u_gbfs_checker (.*);
